FILE: rtl/omni_wheel_drive_kinematics_assert.svh
// Assertion macros for the omni wheel drive kinematics block.
// Used by the top level only; no other dependencies.
`ifndef OMNI_WHEEL_DRIVE_KINEMATICS_ASSERT_SVH
`define OMNI_WHEEL_DRIVE_KINEMATICS_ASSERT_SVH
`define OWK_ASSERT_IMPL(label, a, c) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("owk check failed");
`define OWK_ASSERT_NEXT(label, a, c) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("owk check failed");
`endif

FILE: rtl/owk_pkg.sv
// Types, constants and tables for the omni wheel drive kinematics block.
// No dependencies.
package owk_pkg;
   localparam int MaxStages = 24;
   localparam logic [1:0] CMD_MOVE_FIXED = 2'd0;
   localparam logic [1:0] CMD_MOVE_TURN = 2'd1;
   localparam logic [1:0] CMD_ROTATE = 2'd2;
   localparam logic [1:0] CMD_STOP = 2'd3;
   localparam logic [1:0] CSR_MIN = 2'd0;
   localparam logic [1:0] CSR_MAX = 2'd1;
   localparam logic [1:0] CSR_SLOW = 2'd2;
   localparam logic [1:0] CSR_DEAD = 2'd3;
   localparam logic signed [33:0] CordicK = 34'sd652032874;
   localparam logic signed [17:0] HalfNeg = -18'sd16384;
   localparam logic signed [17:0] Sqrt3Half = 18'sd28378;

   typedef struct packed {
      logic [1:0] cmd;
      logic [15:0] target_angle;
      logic [15:0] speed;
      logic signed [15:0] yaw;
   } req_type;

   typedef struct packed {
      logic [16:0] wheel1_speed;
      logic wheel1_ccw;
      logic [16:0] wheel2_speed;
      logic wheel2_ccw;
      logic [16:0] wheel3_speed;
      logic wheel3_ccw;
      logic at_target;
   } rsp_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } cordic_type;

   function automatic logic signed [33:0] atan_entry(input int i);
      logic signed [33:0] t [MaxStages];
      t = '{34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
            34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
            34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
            34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
            34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
            34'sd652, 34'sd326, 34'sd163, 34'sd81};
      return t[i];
   endfunction
endpackage

FILE: rtl/owk_cordic_cell.sv
// One CORDIC rotation cell pair (target and yaw), registered.
// Depends on owk_pkg.
module owk_cordic_cell import owk_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic clock,
   input  cordic_type a_in,
   input  cordic_type b_in,
   output cordic_type a_out,
   output cordic_type b_out
);
   function automatic cordic_type rot(input cordic_type v);
      cordic_type r;
      if (!v.z[33]) begin
         r.x = v.x - (v.y >>> STAGE);
         r.y = v.y + (v.x >>> STAGE);
         r.z = v.z - atan_entry(STAGE);
      end else begin
         r.x = v.x + (v.y >>> STAGE);
         r.y = v.y - (v.x >>> STAGE);
         r.z = v.z + atan_entry(STAGE);
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      a_out <= rot(a_in);
      b_out <= rot(b_in);
   end
endmodule

FILE: rtl/omni_wheel_drive_kinematics.sv
// Top level of the omni wheel drive kinematics block.
// Depends on owk_pkg, owk_cordic_cell and the assertion header.
//
// Fully pipelined: a command is taken every cycle. Its result is on
// rsp_data with rsp_valid for one cycle. It passes through the angle
// setup stages, the row of CORDIC cells, and the product and wheel sum
// stages. The receiver cannot stall; busy is always low.
`include "omni_wheel_drive_kinematics_assert.svh"
module omni_wheel_drive_kinematics import owk_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  req_type req_data,
   output logic rsp_valid,
   output rsp_type rsp_data,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data
);
   localparam int Lat = CORDIC_STAGES + 8;

   logic [15:0] min_ff, max_ff, slow_ff, dead_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= 16'd10; max_ff <= 16'd200; slow_ff <= 16'd1000; dead_ff <= 16'd100;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MIN: min_ff <= csr_data;
            CSR_MAX: max_ff <= csr_data;
            CSR_SLOW: slow_ff <= csr_data;
            CSR_DEAD: dead_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;
   logic acc;
   assign acc = start && !busy;

   logic [Lat-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[Lat-2:0], acc};
   end

   // stage 0: reduce angles
   logic [15:0] tgt_in, yawm_in, cy_in;
   always_comb begin
      logic signed [17:0] ym, c;
      tgt_in = (req_data.target_angle >= 16'd36000) ?
               req_data.target_angle - 16'd36000 : req_data.target_angle;
      ym = 18'(req_data.yaw);
      if (ym < 0) ym = ym + 18'sd36000;
      if (ym < 0) ym = ym + 18'sd36000;
      yawm_in = ym[15:0];
      c = 18'sd45000 - 18'(req_data.yaw);
      if (c >= 18'sd36000) c = c - 18'sd36000;
      if (c >= 18'sd36000) c = c - 18'sd36000;
      if (c < 0) c = c + 18'sd36000;
      cy_in = c[15:0];
   end

   req_type s0_ff;
   logic [15:0] t0_ff, y0_ff, cy0_ff;
   always_ff @(posedge clock) begin
      s0_ff <= req_data; t0_ff <= tgt_in; y0_ff <= yawm_in; cy0_ff <= cy_in;
   end

   // stage 1: binary angle via reciprocal multiply, exact floor(a*2^32/36000)
   localparam logic [42:0] Recip = 43'd8006399337548;
   logic [58:0] tprod, yprod;
   logic [31:0] tp_ff, yp_ff;
   req_type s1_ff;
   logic [15:0] t1_ff, cy1_ff;
   assign tprod = 59'(t0_ff) * 59'(Recip);
   assign yprod = 59'(y0_ff) * 59'(Recip);
   always_ff @(posedge clock) begin
      tp_ff <= tprod[57:26];
      yp_ff <= yprod[57:26];
      s1_ff <= s0_ff; t1_ff <= t0_ff; cy1_ff <= cy0_ff;
   end

   function automatic cordic_type seed(input logic [31:0] th, output logic flip);
      cordic_type v;
      logic [31:0] t;
      t = th;
      flip = (th >= 32'h4000_0000) && (th < 32'hC000_0000);
      if (flip) t = th + 32'h8000_0000;
      v.x = CordicK; v.y = '0; v.z = 34'(signed'(t));
      return v;
   endfunction

   cordic_type ca [CORDIC_STAGES+1];
   cordic_type cb [CORDIC_STAGES+1];
   logic fa, fb;
   always_comb begin
      ca[0] = seed(tp_ff, fa);
      cb[0] = seed(yp_ff, fb);
   end
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      owk_cordic_cell #(.STAGE(g)) u_cell (.clock(clock), .a_in(ca[g]), .b_in(cb[g]),
         .a_out(ca[g+1]), .b_out(cb[g+1]));
   end

   req_type sd_ff [CORDIC_STAGES];
   logic [15:0] td_ff [CORDIC_STAGES];
   logic [15:0] cyd_ff [CORDIC_STAGES];
   logic [CORDIC_STAGES-1:0] fad_ff, fbd_ff;
   always_ff @(posedge clock) begin
      sd_ff[0] <= s1_ff; td_ff[0] <= t1_ff; cyd_ff[0] <= cy1_ff;
      fad_ff[0] <= fa; fbd_ff[0] <= fb;
      for (int i = 1; i < CORDIC_STAGES; i++) begin
         sd_ff[i] <= sd_ff[i-1]; td_ff[i] <= td_ff[i-1]; cyd_ff[i] <= cyd_ff[i-1];
         fad_ff[i] <= fad_ff[i-1]; fbd_ff[i] <= fbd_ff[i-1];
      end
   end

   function automatic logic signed [17:0] q15(input logic signed [33:0] v, input logic n);
      logic signed [34:0] w, q;
      w = n ? -35'(v) : 35'(v);
      q = w >>> 15;
      if (q > 35'sd32767) q = 35'sd32767;
      if (q < -35'sd32768) q = -35'sd32768;
      return q[17:0];
   endfunction

   // stage A: sin/cos and correction error
   localparam int E = CORDIC_STAGES - 1;
   logic signed [17:0] st_ff, ct_ff, sy_ff, cw_ff;
   req_type sa_ff;
   logic [15:0] err_ff;
   logic neg_a_ff;
   always_ff @(posedge clock) begin
      logic [15:0] t, c;
      t = td_ff[E]; c = cyd_ff[E];
      ct_ff <= q15(ca[CORDIC_STAGES].x, fad_ff[E]);
      st_ff <= q15(ca[CORDIC_STAGES].y, fad_ff[E]);
      cw_ff <= q15(cb[CORDIC_STAGES].x, fbd_ff[E]);
      sy_ff <= q15(cb[CORDIC_STAGES].y, fbd_ff[E]);
      sa_ff <= sd_ff[E];
      err_ff <= (t > c) ? t - c : c - t;
      neg_a_ff <= (t < c && (c - t) <= 16'd18000) || (t > c && (t - c) > 16'd18000);
   end

   // stage B: Vx, Vy and speed*err
   logic signed [34:0] vx_ff, vy_ff;
   logic [31:0] se_ff;
   req_type sb_ff;
   logic [15:0] errb_ff;
   logic sgn_b_ff;
   logic signed [17:0] sy_b_ff, cw_b_ff;
   always_ff @(posedge clock) begin
      vx_ff <= (35'(signed'({1'b0, sa_ff.speed})) * 35'(ct_ff)) >>> 15;
      vy_ff <= (35'(signed'({1'b0, sa_ff.speed})) * 35'(st_ff)) >>> 15;
      se_ff <= 32'(sa_ff.speed) * 32'(err_ff);
      sb_ff <= sa_ff; errb_ff <= err_ff; sgn_b_ff <= neg_a_ff;
      sy_b_ff <= sy_ff; cw_b_ff <= cw_ff;
   end

   // stage C: rotated vector products, correction magnitude
   // speed*err/36000 as (speed*err >> 5) / 1125 by reciprocal multiply
   localparam logic [27:0] SlowRecip = 28'd244335918;
   logic [54:0] qprod;
   assign qprod = 55'(se_ff[31:5]) * 55'(SlowRecip);

   logic signed [34:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [17:0] rot_ff;
   req_type sc_ff;
   always_ff @(posedge clock) begin
      logic [31:0] r;
      p1_ff <= (vx_ff * 35'(cw_b_ff)) >>> 15;
      p2_ff <= (vy_ff * 35'(sy_b_ff)) >>> 15;
      p3_ff <= (vx_ff * 35'(sy_b_ff)) >>> 15;
      p4_ff <= (vy_ff * 35'(cw_b_ff)) >>> 15;
      r = 32'(sb_ff.speed);
      if (errb_ff < slow_ff) r = 32'(qprod[54:38]);
      if (errb_ff > dead_ff) begin
         if (r < 32'(min_ff)) r = 32'(min_ff);
         if (r > 32'(max_ff)) r = 32'(max_ff);
      end else r = 32'd0;
      rot_ff <= sgn_b_ff ? -18'(r[16:0]) : 18'(r[16:0]);
      sc_ff <= sb_ff;
   end

   // stage D: Vx', Vy'
   logic signed [34:0] vxp_ff, vyp_ff;
   logic signed [17:0] rotd_ff;
   req_type sdd_ff;
   always_ff @(posedge clock) begin
      vxp_ff <= p1_ff - p2_ff; vyp_ff <= p3_ff + p4_ff;
      rotd_ff <= rot_ff; sdd_ff <= sc_ff;
   end

   // stage E: wheel projections
   logic signed [34:0] pp_ff, mm_ff, vxe_ff;
   logic signed [17:0] rote_ff;
   req_type se2_ff;
   always_ff @(posedge clock) begin
      pp_ff <= (vxp_ff * 35'(HalfNeg)) >>> 15;
      mm_ff <= (vyp_ff * 35'(Sqrt3Half)) >>> 15;
      vxe_ff <= vxp_ff; rote_ff <= rotd_ff; se2_ff <= sdd_ff;
   end

   function automatic logic [17:0] mag(input logic signed [35:0] w);
      logic signed [35:0] m;
      m = w[35] ? -w : w;
      return {(w <= 0), (m > 36'sd131071) ? 17'h1FFFF : m[16:0]};
   endfunction

   // stage F: sums and output
   always_ff @(posedge clock) begin
      logic signed [35:0] w1, w2, w3;
      logic [17:0] m1, m2, m3;
      w1 = '0; w2 = '0; w3 = '0;
      if (se2_ff.cmd == CMD_MOVE_FIXED || se2_ff.cmd == CMD_MOVE_TURN) begin
         w1 = 36'(vxe_ff); w2 = 36'(pp_ff) - 36'(mm_ff); w3 = 36'(pp_ff) + 36'(mm_ff);
         if (se2_ff.cmd == CMD_MOVE_TURN) begin
            w1 = w1 + 36'(rote_ff); w2 = w2 + 36'(rote_ff); w3 = w3 + 36'(rote_ff);
         end
      end else if (se2_ff.cmd == CMD_ROTATE) begin
         w1 = 36'(rote_ff); w2 = w1; w3 = w1;
      end
      m1 = mag(w1); m2 = mag(w2); m3 = mag(w3);
      rsp_data <= {m1[16:0], m1[17], m2[16:0], m2[17], m3[16:0], m3[17],
                   (se2_ff.cmd == CMD_ROTATE) && (rote_ff == 0)};
   end
   assign rsp_valid = vld_ff[Lat-1];

   `OWK_ASSERT_NEXT(a_pipe_valid, acc, vld_ff[0])
   `OWK_ASSERT_IMPL(a_stop_ccw, rsp_valid && rsp_data.wheel1_speed == 0, rsp_data.wheel1_ccw)
   `OWK_ASSERT_IMPL(a_busy_low, 1'b1, !busy)
endmodule
